// ===== hdl/ncfs_pkg.sv =====
// Shared types, character codes and register indexes for the nested container
// field splitter. No dependencies; every other file imports this package.

package ncfs_pkg;

  // Container kind codes held on the stack
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_QUOTE   = 2'd0;
  localparam kind_t KIND_BRACKET = 2'd1;
  localparam kind_t KIND_BRACE   = 2'd2;
  localparam kind_t KIND_NONE    = 2'd3;

  // Character codes
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  // Configuration register indexes and reset values
  localparam logic CFG_DELIMITER  = 1'b0;
  localparam logic CFG_RESPECT    = 1'b1;
  localparam logic [7:0] DELIMITER_RST = 8'd44;
  localparam logic RESPECT_RST         = 1'b1;

  // Stack request from the control logic, applied on one step
  typedef struct packed {
    logic  push;
    logic  pop;
    logic  clear;
    kind_t kind;
  } stack_op_t;

  // Kind that a byte opens, or KIND_NONE
  function automatic kind_t open_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_QUOTE:    k = KIND_QUOTE;
      CH_LBRACKET: k = KIND_BRACKET;
      CH_LBRACE:   k = KIND_BRACE;
      default:     k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Kind that a byte closes, or KIND_NONE
  function automatic kind_t close_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_QUOTE:    k = KIND_QUOTE;
      CH_RBRACKET: k = KIND_BRACKET;
      CH_RBRACE:   k = KIND_BRACE;
      default:     k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/ncfs_stack.sv =====
// Container kind stack: a top-of-stack register, a registered copy of the entry
// below it, and a memory for the deeper entries. Depends on ncfs_pkg.

module ncfs_stack #(
  parameter int MAX_NESTING = 8,
  localparam int DW = $clog2(MAX_NESTING + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ncfs_pkg::stack_op_t op,
  output logic [DW-1:0]       depth,
  output ncfs_pkg::kind_t     top_kind
);
  import ncfs_pkg::*;

  localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  logic [DW-1:0] depth_r, depth_nxt;
  kind_t         top_r;
  kind_t         below_r;
  kind_t         mem [MAX_NESTING];
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign wr_addr  = AW'(depth_r - DW'(1));
  assign rd_addr  = AW'(depth_r - DW'(3));
  assign depth    = depth_r;
  assign top_kind = top_r;

  // Depth counter
  always_comb begin
    depth_nxt = depth_r;
    if (op.clear) begin
      depth_nxt = '0;
    end else if (op.push) begin
      depth_nxt = depth_r + DW'(1);
    end else if (op.pop) begin
      depth_nxt = depth_r - DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  // Top entry: a push loads the new kind, a pop takes the entry below
  always_ff @(posedge clk) begin
    if (op.push) begin
      top_r <= op.kind;
    end else if (op.pop) begin
      top_r <= below_r;
    end
  end

  // Deeper entries: a push spills the old top, a pop prefetches the next one
  always_ff @(posedge clk) begin
    if (op.push) begin
      if (depth_r != '0) begin
        mem[wr_addr] <= top_r;
      end
      below_r <= top_r;
    end else if (op.pop && depth_r >= DW'(3)) begin
      below_r <= mem[rd_addr];
    end
  end

  // The depth never passes the stack size
  assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_NESTING))
    else $error("stack depth beyond capacity");

  // A clear empties the stack on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    op.clear |=> depth_r == '0)
    else $error("stack not empty after clear");

  // A pop is only requested on a nonempty stack
  assert property (@(posedge clk) disable iff (!rst_n)
    op.pop |-> depth_r != '0)
    else $error("pop on an empty stack");

endmodule

// ===== hdl/nested_container_field_splitter_unit.sv =====
// Top level of the nested container field splitter: input register, split and
// nesting control, result register. Depends on ncfs_pkg and ncfs_stack.
//
//  Channel | Direction | Handshake          | Contents
//  in_     | slave     | tvalid/tready      | tdata = char_in, tlast = last_char
//  out_    | master    | tvalid/tready      | tdata = char_out, nest_level, nest_overflow;
//          |           |                    | tuser = keep, tlast = token_end
//  cfg_    | write     | cfg_we             | cfg_addr selects delimiter or mode
//
// One request per cycle is taken and one result per cycle is given while the output
// is not stalled; an accepted request passes the input register and then the result
// register before its result is valid.
// The stack top and the entry below it sit in registers, so each byte is decided
// by one short level of logic.
// Reset is synchronous and active low; it empties the stack and both registers.
// A stall on the output holds the result register and, behind it, the input
// register; the stack advances only when a byte moves into the result register.

module nested_container_field_splitter_unit #(
  parameter int MAX_NESTING = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tlast,   // last_char
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] char_out, [11:8] nest_level, [12] nest_overflow
  output logic        out_tuser,  // [0] keep
  output logic        out_tlast,  // token_end
  // Configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);
  import ncfs_pkg::*;

  localparam int DW = $clog2(MAX_NESTING + 1);
  localparam int LW = (DW > 4) ? DW : 4;

  // Configuration registers
  logic [7:0] delimiter_r;
  logic       respect_r;

  // Input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r;
  logic       s1_last_r;

  // Result register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r;
  logic       out_keep_r;
  logic       out_tend_r;
  logic [3:0] out_level_r;
  logic       out_ovf_r;

  // Control state
  logic       prev_bs_r, prev_bs_nxt;

  logic          in_accept;
  logic          advance;
  logic [DW-1:0] depth;
  kind_t         top_kind;
  stack_op_t     op;
  kind_t         ok;
  kind_t         ck;
  logic          full;
  logic          want_push;
  logic          do_pop;
  logic          ovf;
  logic          keep;
  logic          tend;
  logic [DW-1:0] depth_after;
  logic [LW-1:0] depth_ext;
  logic [3:0]    level;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delimiter_r <= DELIMITER_RST;
      respect_r   <= RESPECT_RST;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_DELIMITER) begin
        delimiter_r <= cfg_wdata;
      end
      if (cfg_addr == CFG_RESPECT) begin
        respect_r <= cfg_wdata[0];
      end
    end
  end

  // Handshake and pipeline movement
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // Split and nesting decision for the byte in the input register
  always_comb begin
    ok        = open_kind(s1_char_r);
    ck        = close_kind(s1_char_r);
    full      = (depth == DW'(MAX_NESTING));
    keep      = 1'b1;
    tend      = 1'b0;
    want_push = 1'b0;
    do_pop    = 1'b0;
    if (depth == '0) begin
      if (s1_char_r == delimiter_r) begin
        keep = 1'b0;
        tend = 1'b1;
      end else if (respect_r && ok != KIND_NONE && !prev_bs_r) begin
        want_push = 1'b1;
      end
    end else begin
      if (ck == top_kind && !prev_bs_r) begin
        do_pop = 1'b1;
      end else if (ok != KIND_NONE) begin
        want_push = 1'b1;
      end
    end
    ovf = want_push && full;
    if (s1_last_r) begin
      tend = 1'b1;
    end
    prev_bs_nxt = !s1_last_r && (s1_char_r == CH_BACKSLASH);
  end

  // Depth seen by the result, before the clear on the final byte
  always_comb begin
    depth_after = depth;
    if (want_push && !full) begin
      depth_after = depth + DW'(1);
    end else if (do_pop) begin
      depth_after = depth - DW'(1);
    end
    depth_ext = LW'(depth_after);
    level     = (depth_ext > LW'(15)) ? 4'hF : depth_ext[3:0];
  end

  // Stack requests, applied only when the byte moves on
  always_comb begin
    op.push  = advance && want_push && !full;
    op.pop   = advance && do_pop;
    op.clear = advance && s1_last_r;
    op.kind  = ok;
  end

  ncfs_stack #(
    .MAX_NESTING(MAX_NESTING)
  ) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .depth    (depth),
    .top_kind (top_kind)
  );

  // Escape flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_bs_r <= 1'b0;
    end else if (advance) begin
      prev_bs_r <= prev_bs_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char_r  <= s1_char_r;
      out_keep_r  <= keep;
      out_tend_r  <= tend;
      out_level_r <= level;
      out_ovf_r   <= ovf;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_ovf_r, out_level_r, out_char_r};
  assign out_tuser  = out_keep_r;
  assign out_tlast  = out_tend_r;

  // A dropped byte always ends a token
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_keep_r) |-> out_tend_r)
    else $error("delimiter without token end");

  // The final byte leaves no escape pending and an empty stack
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_last_r) |=> !prev_bs_r && depth == '0)
    else $error("state not cleared after final byte");

  // An overflow only happens on a full stack, and the depth stays there unless the byte is the final one
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && ovf) |=> $stable(depth) || $past(s1_last_r))
    else $error("depth moved on an overflowed push");

endmodule
